// ===== hw/rtl/itp_pkg.sv =====
// shared types, character codes and classify functions for the infix to postfix converter
// no dependencies; used by the stack cells and the top level
`default_nettype none

package itp_pkg;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NONE   = 8'h00;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_END       = 2'd1,
        KIND_OVERFLOW  = 2'd2,
        KIND_UNMATCHED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STK_HOLD = 2'd0,
        STK_PUSH = 2'd1,
        STK_POP  = 2'd2
    } t_stk_op;

    typedef enum logic [1:0] {
        MODE_ALNUM = 2'd0,
        MODE_OPEN  = 2'd1,
        MODE_CLOSE = 2'd2,
        MODE_OPER  = 2'd3
    } t_mode;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        case (c)
            CH_PLUS, CH_MINUS: p = 2'd1;
            CH_STAR, CH_SLASH: p = 2'd2;
            default:           p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic t_mode classify(input logic [7:0] c);
        t_mode m;
        if (is_alnum(c)) begin
            m = MODE_ALNUM;
        end else if (c == CH_LPAREN) begin
            m = MODE_OPEN;
        end else if (c == CH_RPAREN) begin
            m = MODE_CLOSE;
        end else begin
            m = MODE_OPER;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/itp_in_if.sv =====
// input channel: one infix character per transfer
// no dependencies
`default_nettype none

interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       expr_last;

    modport source (output valid, output char_in, output expr_last, input ready);
    modport sink   (input valid, input char_in, input expr_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/itp_out_if.sv =====
// output channel: one postfix character or status code per transfer
// no dependencies
`default_nettype none

interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic [1:0] kind;
    logic       run_end;

    modport source (output valid, output char_out, output kind, output run_end, input ready);
    modport sink   (input valid, input char_out, input kind, input run_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/itp_cell.sv =====
// one entry of the operator stack; shifts toward the top on pop, away from it on push
// depends on itp_pkg
`default_nettype none

module itp_cell (
    input  wire logic             i_clk,
    input  wire itp_pkg::t_stk_op i_op,
    input  wire logic [7:0]       i_from_up,
    input  wire logic [7:0]       i_from_down,
    output logic [7:0]            o_data
);
    import itp_pkg::*;

    logic [7:0] r_data;

    always_ff @(posedge i_clk) begin
        case (i_op)
            STK_PUSH: r_data <= i_from_up;
            STK_POP:  r_data <= i_from_down;
            default:  r_data <= r_data;
        endcase
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== hw/rtl/itp_stack.sv =====
// operator stack as a row of shifting cells, cell 0 holds the top entry
// depends on itp_pkg and itp_cell
`default_nettype none

module itp_stack #(
    parameter int DEPTH = 32
) (
    input  wire logic             i_clk,
    input  wire itp_pkg::t_stk_op i_op,
    input  wire logic [7:0]       i_push_data,
    output logic [7:0]            o_top,
    output logic [7:0]            o_second
);
    import itp_pkg::*;

    logic [7:0] w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [7:0] w_up;
        logic [7:0] w_down;

        if (g == 0) begin : g_first
            assign w_up = i_push_data;
        end else begin : g_mid_up
            assign w_up = w_data[g-1];
        end

        // bottom cell refills itself on pop, its value is then beyond the count
        if (g == DEPTH - 1) begin : g_last
            assign w_down = w_data[g];
        end else begin : g_mid_down
            assign w_down = w_data[g+1];
        end

        itp_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (i_op),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_data      (w_data[g])
        );
    end

    assign o_top    = w_data[0];
    assign o_second = w_data[1];

endmodule

`default_nettype wire

// ===== hw/rtl/infix_to_postfix_converter_top.sv =====
// infix to postfix converter: control sequencer, output register and the cell stack
// depends on itp_pkg, itp_in_if, itp_out_if, itp_stack
`default_nettype none

// Takes an infix expression one character per input transfer and returns the postfix
// form one character per output transfer, using a stack of STACK_DEPTH operator cells
// that shift one entry per cycle. An input is accepted in S_IDLE and handled in S_OP
// one result or stack move at a time: a letter or digit gives one result, an operator
// pops its entries and then pushes itself, and the character marked last goes on to
// S_FLUSH, which pops every entry left and then gives the end marker. Results wait in an
// output register; a stalled output stalls the sequencer but not the next input
// transfer of a character that gives no result. Overflow and an unmatched close paren
// are reported by a status result, after which the rest of the expression is dropped
// up to its last character. No clearing pass is needed after reset.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    itp_in_if.sink     i_in,
    itp_out_if.source  o_out
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_OP    = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_dropping, n_dropping;
    logic [7:0]    r_char, n_char;
    logic          r_last, n_last;
    t_mode         r_mode, n_mode;
    logic [1:0]    r_prec, n_prec;

    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_char, n_out_char;
    t_kind         r_out_kind, n_out_kind;
    logic          r_out_run_end, n_out_run_end;

    t_stk_op       w_stk_op;
    logic [7:0]    w_push_data;
    logic [7:0]    w_top;
    logic [7:0]    w_second;

    logic          w_accept;
    logic          w_can_emit;
    logic          w_emit;
    logic [7:0]    w_e_char;
    t_kind         w_e_kind;
    logic          w_e_end;
    logic          w_err;
    t_kind         w_err_kind;
    logic          w_zero;
    logic          w_one;
    logic          w_full;
    logic          w_top_open;
    logic          w_sec_open;

    itp_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk       (i_clk),
        .i_op        (w_stk_op),
        .i_push_data (w_push_data),
        .o_top       (w_top),
        .o_second    (w_second)
    );

    assign i_in.ready     = (r_state == S_IDLE);
    assign w_accept       = i_in.valid && i_in.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.char_out = r_out_char;
    assign o_out.kind     = r_out_kind;
    assign o_out.run_end  = r_out_run_end;

    assign w_can_emit = !r_out_valid || o_out.ready;
    assign w_zero     = (r_count == '0);
    assign w_one      = (r_count == CW'(1));
    assign w_full     = (r_count >= CW'(STACK_DEPTH));
    assign w_top_open = (w_top == CH_LPAREN);
    assign w_sec_open = (w_second == CH_LPAREN);
    assign w_push_data = r_char;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dropping = r_dropping;
        n_char     = r_char;
        n_last     = r_last;
        n_mode     = r_mode;
        n_prec     = r_prec;
        w_stk_op   = STK_HOLD;
        w_emit     = 1'b0;
        w_e_char   = CH_NONE;
        w_e_kind   = KIND_CHAR;
        w_e_end    = 1'b0;
        w_err      = 1'b0;
        w_err_kind = KIND_OVERFLOW;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_dropping) begin
                        if (i_in.expr_last) begin
                            n_dropping = 1'b0;
                            n_count    = '0;
                        end
                    end else begin
                        n_char  = i_in.char_in;
                        n_last  = i_in.expr_last;
                        n_mode  = classify(i_in.char_in);
                        n_prec  = prec_of(i_in.char_in);
                        n_state = S_OP;
                    end
                end
            end
            S_OP: begin
                case (r_mode)
                    MODE_ALNUM: begin
                        if (w_can_emit) begin
                            w_emit   = 1'b1;
                            w_e_char = r_char;
                            w_e_end  = !r_last;
                            n_state  = r_last ? S_FLUSH : S_IDLE;
                        end
                    end
                    MODE_OPEN: begin
                        if (w_full) begin
                            w_err      = 1'b1;
                            w_err_kind = KIND_OVERFLOW;
                        end else begin
                            w_stk_op = STK_PUSH;
                            n_count  = r_count + CW'(1);
                            n_state  = r_last ? S_FLUSH : S_IDLE;
                        end
                    end
                    MODE_CLOSE: begin
                        if (w_zero) begin
                            w_err      = 1'b1;
                            w_err_kind = KIND_UNMATCHED;
                        end else if (!w_top_open) begin
                            if (w_can_emit) begin
                                w_emit   = 1'b1;
                                w_e_char = w_top;
                                // last result when the matching paren sits right below
                                w_e_end  = !r_last && !w_one && w_sec_open;
                                w_stk_op = STK_POP;
                                n_count  = r_count - CW'(1);
                            end
                        end else begin
                            // matching paren is discarded silently
                            w_stk_op = STK_POP;
                            n_count  = r_count - CW'(1);
                            n_state  = r_last ? S_FLUSH : S_IDLE;
                        end
                    end
                    default: begin
                        if (!w_zero && !w_top_open && (prec_of(w_top) >= r_prec)) begin
                            if (w_can_emit) begin
                                w_emit   = 1'b1;
                                w_e_char = w_top;
                                // popping stops after this one and the push cannot overflow
                                w_e_end  = !r_last && (w_one || w_sec_open ||
                                           (prec_of(w_second) < r_prec));
                                w_stk_op = STK_POP;
                                n_count  = r_count - CW'(1);
                            end
                        end else if (w_full) begin
                            w_err      = 1'b1;
                            w_err_kind = KIND_OVERFLOW;
                        end else begin
                            w_stk_op = STK_PUSH;
                            n_count  = r_count + CW'(1);
                            n_state  = r_last ? S_FLUSH : S_IDLE;
                        end
                    end
                endcase

                if (w_err && w_can_emit) begin
                    w_emit     = 1'b1;
                    w_e_char   = CH_NONE;
                    w_e_kind   = w_err_kind;
                    w_e_end    = 1'b1;
                    n_count    = '0;
                    n_dropping = !r_last;
                    n_state    = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (w_can_emit) begin
                    w_emit = 1'b1;
                    if (!w_zero) begin
                        w_e_char = w_top;
                        w_stk_op = STK_POP;
                        n_count  = r_count - CW'(1);
                    end else begin
                        w_e_kind = KIND_END;
                        w_e_end  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_char    = r_out_char;
        n_out_kind    = r_out_kind;
        n_out_run_end = r_out_run_end;
        if (w_emit) begin
            n_out_valid   = 1'b1;
            n_out_char    = w_e_char;
            n_out_kind    = w_e_kind;
            n_out_run_end = w_e_end;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dropping  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropping  <= n_dropping;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char        <= n_char;
        r_last        <= n_last;
        r_mode        <= n_mode;
        r_prec        <= n_prec;
        r_out_char    <= n_out_char;
        r_out_kind    <= n_out_kind;
        r_out_run_end <= n_out_run_end;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> (r_state == S_IDLE))
        else $error("dropping while sequencer busy");

    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind != KIND_CHAR)) |-> r_out_run_end)
        else $error("status result not marked as run end");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> r_last)
        else $error("flush without last character");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_dropping) |=> (r_state == S_OP))
        else $error("accepted character not processed");

endmodule

`default_nettype wire

// ===== test/tb_infix_to_postfix_converter_top.sv =====
// testbench for infix_to_postfix_converter_top: random bursty sender, stalling receiver,
// and a self-checking shunting-yard predictor of the postfix stream
// depends on itp_pkg, itp_in_if, itp_out_if and the converter rtl
`default_nettype none

module tb_infix_to_postfix_converter_top;
    import itp_pkg::*;

    localparam int STACK_DEPTH = 32;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_infix_item;

    typedef struct packed {
        logic [7:0] ch;
        t_kind      kind;
        logic       run_end;
    } t_postfix;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_PERIODIC,
        RX_RANDOM
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    itp_in_if  in_if ();
    itp_out_if out_if ();

    infix_to_postfix_converter_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_infix_item pending[$];
    t_postfix    postfix_q[$];
    t_infix_item next_item;
    int          err_count = 0;
    int          cycle_cnt = 0;

    // predictor state
    logic [7:0] op_stk[STACK_DEPTH];
    int         stk_cnt = 0;
    bit         drop_rest = 1'b0;

    int       burst_left = 0;
    int       gap_left = 0;
    int       rx_cyc = 0;
    int       rx_period = 3;
    t_rx_mode rx_mode = RX_ALWAYS;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [1:0] rank_of(input logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS) return 2'd1;
        if (c == CH_STAR || c == CH_SLASH) return 2'd2;
        return 2'd0;
    endfunction

    function automatic bit is_operand(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic t_postfix pop_top();
        t_postfix r;
        r = '{op_stk[stk_cnt-1], KIND_CHAR, 1'b0};
        stk_cnt--;
        return r;
    endfunction

    task automatic predict_postfix(input logic [7:0] c, input logic last);
        t_postfix   res[$];
        t_kind      fault;
        bit         faulted;
        logic [1:0] p;
        if (drop_rest) begin
            if (last) begin
                drop_rest = 1'b0;
                stk_cnt = 0;
            end
            return;
        end
        faulted = 1'b0;
        fault = KIND_CHAR;
        if (is_operand(c)) begin
            res.push_back('{c, KIND_CHAR, 1'b0});
        end else if (c == CH_RPAREN) begin
            while (stk_cnt > 0 && op_stk[stk_cnt-1] != CH_LPAREN) res.push_back(pop_top());
            if (stk_cnt == 0) begin
                faulted = 1'b1;
                fault = KIND_UNMATCHED;
            end else begin
                stk_cnt--;
            end
        end else begin
            // an open paren pops nothing; others pop equal or higher ranks, up to an open paren
            if (c != CH_LPAREN) begin
                p = rank_of(c);
                while (stk_cnt > 0 && op_stk[stk_cnt-1] != CH_LPAREN &&
                       rank_of(op_stk[stk_cnt-1]) >= p) res.push_back(pop_top());
            end
            if (stk_cnt >= STACK_DEPTH) begin
                faulted = 1'b1;
                fault = KIND_OVERFLOW;
            end else begin
                op_stk[stk_cnt] = c;
                stk_cnt++;
            end
        end
        if (faulted) begin
            res.push_back('{CH_NONE, fault, 1'b0});
            stk_cnt = 0;
            drop_rest = !last;
        end else if (last) begin
            while (stk_cnt > 0) res.push_back(pop_top());
            res.push_back('{CH_NONE, KIND_END, 1'b0});
        end
        if (res.size() > 0) res[res.size()-1].run_end = 1'b1;
        foreach (res[i]) postfix_q.push_back(res[i]);
    endtask

    task automatic add_char(input logic [7:0] c, input logic last);
        pending.push_back('{c, last});
    endtask

    task automatic add_text(input string s, input bit mark_last);
        for (int i = 0; i < s.len(); i++) add_char(s[i], mark_last && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] rand_operand();
        case ($urandom_range(0, 2))
            0:       return 8'("0" + $urandom_range(0, 9));
            1:       return 8'("A" + $urandom_range(0, 25));
            default: return 8'("a" + $urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] rand_oper();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1:    c = CH_PLUS;
            2, 3:    c = CH_MINUS;
            4, 5:    c = CH_STAR;
            6, 7:    c = CH_SLASH;
            default: begin
                // any other non-operand byte acts as a lowest-rank operator
                c = 8'($urandom_range(0, 255));
                while (is_operand(c) || c == CH_LPAREN || c == CH_RPAREN)
                    c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    // every char of the push run raises the stack by one: opens, and operators right after an open
    task automatic gen_deep(input int n_push, input int n_tail);
        logic [7:0] c;
        c = CH_NONE;
        for (int i = 0; i < n_push; i++) begin
            c = (c == CH_LPAREN && $urandom_range(0, 1)) ? rand_oper() : CH_LPAREN;
            add_char(c, n_tail == 0 && i == n_push - 1);
        end
        for (int i = 0; i < n_tail; i++) begin
            case ($urandom_range(0, 3))
                0:       c = rand_operand();
                1:       c = rand_oper();
                2:       c = CH_RPAREN;
                default: c = 8'($urandom_range(0, 255));
            endcase
            add_char(c, i == n_tail - 1);
        end
    endtask

    task automatic gen_infix(input bit broken);
        logic [7:0] q[$];
        int         n_ops;
        int         depth;
        int         pos;
        n_ops = $urandom_range(0, 6);
        depth = 0;
        for (int i = 0; i <= n_ops; i++) begin
            while ($urandom_range(0, 3) == 0 && depth < 8) begin
                q.push_back(CH_LPAREN);
                depth++;
            end
            q.push_back(rand_operand());
            while (depth > 0 && $urandom_range(0, 2) == 0) begin
                q.push_back(CH_RPAREN);
                depth--;
            end
            if (i < n_ops) q.push_back(rand_oper());
        end
        // sometimes leave opens behind so they get flushed at the end
        if ($urandom_range(0, 4) != 0) begin
            while (depth > 0) begin
                q.push_back(CH_RPAREN);
                depth--;
            end
        end
        if (broken) begin
            pos = $urandom_range(0, q.size() - 1);
            case ($urandom_range(0, 2))
                0:       q[pos] = CH_RPAREN;
                1:       q[pos] = CH_LPAREN;
                default: q[pos] = 8'($urandom_range(0, 255));
            endcase
        end
        foreach (q[i]) add_char(q[i], i == q.size() - 1);
    endtask

    task automatic gen_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) add_char(8'($urandom_range(0, 255)), i == n - 1);
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.char_in   <= 8'h00;
            in_if.expr_last <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) predict_postfix(in_if.char_in, in_if.expr_last);
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    next_item = pending.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.char_in   <= next_item.ch;
                    in_if.expr_last <= next_item.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern is redrawn at random from always ready, periodic and random stalls
    always @(posedge i_clk) begin
        t_postfix want;
        rx_cyc++;
        if (rx_cyc % 64 == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_period = $urandom_range(2, 7);
        end
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:   out_if.ready <= 1'b1;
                RX_PERIODIC: out_if.ready <= (rx_cyc % rx_period) != 0;
                default:     out_if.ready <= $urandom_range(0, 3) != 0;
            endcase
            if (out_if.valid && out_if.ready) begin
                if (postfix_q.size() == 0) begin
                    $error("result transfer with nothing pending: char_out %h kind %0d",
                           out_if.char_out, out_if.kind);
                    err_count++;
                end else begin
                    want = postfix_q.pop_front();
                    if (out_if.char_out !== want.ch) begin
                        $error("char_out: expected %h, got %h", want.ch, out_if.char_out);
                        err_count++;
                    end
                    if (out_if.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
                        err_count++;
                    end
                    if (out_if.run_end !== want.run_end) begin
                        $error("run_end: expected %0d, got %0d", want.run_end, out_if.run_end);
                        err_count++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        int pick;
        i_rst_n = 1'b0;

        // operator meeting an open paren stops popping there
        add_text("A*(0-z)/Z", 1'b1);
        // control and non-ascii bytes are lowest-rank operators
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b1);
        // unmatched close mid-expression, rest dropped up to the last char
        add_text(")a", 1'b0);
        add_char(8'h80, 1'b1);
        // unmatched close on the last char
        add_text("a+b)", 1'b1);
        // open paren left at the end gets flushed
        add_text("(a+", 1'b1);
        add_text("b", 1'b1);

        // full stack flush, then overflow with and without a dropped tail
        gen_deep(STACK_DEPTH, 0);
        gen_deep(STACK_DEPTH + 1, 3);
        gen_deep(STACK_DEPTH + 1, 0);
        while (pending.size() < 210) begin
            pick = $urandom_range(0, 19);
            if (pick < 13)      gen_infix(1'b0);
            else if (pick < 16) gen_infix(1'b1);
            else if (pick < 19) gen_noise();
            else                gen_deep($urandom_range(20, STACK_DEPTH + 2),
                                         $urandom_range(0, 4));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || in_if.valid) @(posedge i_clk);
        while (postfix_q.size() != 0) @(posedge i_clk);
        repeat (STACK_DEPTH + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/itp_pkg.sv
hw/rtl/itp_in_if.sv
hw/rtl/itp_out_if.sv
hw/rtl/itp_cell.sv
hw/rtl/itp_stack.sv
hw/rtl/infix_to_postfix_converter_top.sv
test/tb_infix_to_postfix_converter_top.sv
